### rtl/core/usm3_pkg.sv
package usm3_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECT_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

    // Register widths and reset values
    localparam int GAIN_W = 12;
    localparam int SIZE_W = 10;
    localparam logic [GAIN_W-1:0] DIRECT_GAIN_RESET = 12'd768;
    localparam logic [GAIN_W-1:0] BLUR_GAIN_RESET   = 12'd512;
    localparam logic [SIZE_W-1:0] FRAME_SIZE_RESET  = 10'd512;
    localparam int MIN_FRAME_SIZE = 3;

    // Pixel path
    localparam int PIX_W   = 8;
    localparam int TAG_W   = 9;
    localparam int SUM_W   = 12;
    localparam int PROD_W  = GAIN_W + PIX_W;
    localparam int FRAC_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Result slots of one input item (bit positions in the result mask)
    localparam logic [1:0] K_UP_LEFT   = 2'd0;  // row r-1, column c-1
    localparam logic [1:0] K_UP_RIGHT  = 2'd1;  // row r-1, column c
    localparam logic [1:0] K_LOW_LEFT  = 2'd2;  // row r,   column c-1
    localparam logic [1:0] K_LOW_RIGHT = 2'd3;  // row r,   column c

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef pix_t  [2:0] wcol_t;  // [0] row r-2, [1] row r-1, [2] row r
    typedef wcol_t [2:0] win_t;   // [0] oldest column

    // Item state handed from the line-store stage to the sequencer
    typedef struct packed {
        logic [3:0] mask;
        logic       first_col;
        logic       first_row;
        tag_t       row_prev;
        tag_t       row_cur;
        tag_t       col_prev;
        tag_t       col_cur;
    } item_t;

    // One result request for the sharpen pipeline
    typedef struct packed {
        pix_t blur;
        pix_t center;
        tag_t row;
        tag_t col;
        logic last;
    } tap_t;

    // One finished result
    typedef struct packed {
        pix_t pixel;
        tag_t row;
        tag_t col;
        logic last;
    } res_t;

endpackage

### rtl/core/usm3_line_buf.sv
module usm3_line_buf #(
    parameter int DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    input  usm3_pkg::pix_t                pix_in,
    input  logic                          wr_en,
    output usm3_pkg::pix_t                cur_pix,
    output usm3_pkg::pix_t                above,
    output usm3_pkg::pix_t                above2
);
    import usm3_pkg::*;

    localparam int AW = $clog2(DEPTH);

    pix_t mem_a [DEPTH];  // row r-1
    pix_t mem_b [DEPTH];  // row r-2

    logic [AW-1:0] addr_reg;
    pix_t          pix_reg;
    pix_t          above_reg;
    pix_t          above2_reg;
    logic          fwd;

    // Same column read while the previous item writes it back
    assign fwd = wr_en && (addr_reg == rd_addr);

    // Write-back: new pixel into row r-1 store, old r-1 into row r-2 store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[addr_reg] <= pix_reg;
            mem_b[addr_reg] <= above_reg;
        end
    end

    // Registered read with forwarding
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_reg   <= rd_addr;
            pix_reg    <= pix_in;
            above_reg  <= fwd ? pix_reg : mem_a[rd_addr];
            above2_reg <= fwd ? above_reg : mem_b[rd_addr];
        end
    end

    assign cur_pix = pix_reg;
    assign above   = above_reg;
    assign above2  = above2_reg;

endmodule

### rtl/core/usm3_seq.sv
module usm3_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  usm3_pkg::item_t item,
    input  usm3_pkg::pix_t  cur_pix,
    input  usm3_pkg::pix_t  above,
    input  usm3_pkg::pix_t  above2,
    input  logic            tap_ready,
    output logic            job_free,
    output logic            job_busy,
    output logic            tap_valid,
    output usm3_pkg::tap_t  tap
);
    import usm3_pkg::*;

    win_t       win_reg;
    win_t       win_next;
    win_t       jwin_reg;
    item_t      job_reg;
    logic [3:0] mask_reg;
    logic [3:0] mask_rest;
    logic       issue;
    logic [1:0] k;
    logic       sel_right;
    logic       sel_low;
    logic       top_alt;
    wcol_t      col_l;
    wcol_t      col_m;
    wcol_t      col_r;
    pix_t       tl, tm, tr, ml, mm, mr, bl, bm, br;
    logic [SUM_W-1:0] sum;

    // Window shift: new column from the line stores and the current pixel
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = {cur_pix, above, above2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (commit)
        begin
            win_reg <= win_next;
        end
    end

    // Job control: one mask bit per pending result
    assign mask_rest = mask_reg & (mask_reg - 4'd1);
    assign job_busy  = (mask_reg != '0);
    assign tap_valid = job_busy;
    assign issue     = job_busy && tap_ready;
    assign job_free  = !job_busy || (issue && (mask_rest == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (commit && (item.mask != '0))
        begin
            mask_reg <= item.mask;
        end
        else if (issue)
        begin
            mask_reg <= mask_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && (item.mask != '0))
        begin
            job_reg  <= item;
            jwin_reg <= win_next;
        end
    end

    // Lowest pending result goes first
    always_comb
    begin
        if (mask_reg[K_UP_LEFT])
            k = K_UP_LEFT;
        else if (mask_reg[K_UP_RIGHT])
            k = K_UP_RIGHT;
        else if (mask_reg[K_LOW_LEFT])
            k = K_LOW_LEFT;
        else
            k = K_LOW_RIGHT;
    end

    assign sel_right = (k == K_UP_RIGHT) || (k == K_LOW_RIGHT);
    assign sel_low   = (k == K_LOW_LEFT) || (k == K_LOW_RIGHT);
    assign top_alt   = sel_low || job_reg.first_row;

    // Mirrored border: pick columns, then rows
    assign col_l = (sel_right || job_reg.first_col) ? jwin_reg[1] : jwin_reg[0];
    assign col_m = sel_right ? jwin_reg[2] : jwin_reg[1];
    assign col_r = jwin_reg[2];

    assign tl = top_alt ? col_l[1] : col_l[0];
    assign tm = top_alt ? col_m[1] : col_m[0];
    assign tr = top_alt ? col_r[1] : col_r[0];
    assign ml = sel_low ? col_l[2] : col_l[1];
    assign mm = sel_low ? col_m[2] : col_m[1];
    assign mr = sel_low ? col_r[2] : col_r[1];
    assign bl = col_l[2];
    assign bm = col_m[2];
    assign br = col_r[2];

    // 1-2-1 blur, divide by 16
    assign sum = SUM_W'(tl) + SUM_W'(tr) + SUM_W'(bl) + SUM_W'(br)
               + ((SUM_W'(tm) + SUM_W'(bm) + SUM_W'(ml) + SUM_W'(mr)) << 1)
               + (SUM_W'(mm) << 2);

    always_comb
    begin
        tap.blur   = sum[SUM_W-1:SUM_W-PIX_W];
        tap.center = mm;
        tap.row    = sel_low ? job_reg.row_cur : job_reg.row_prev;
        tap.col    = sel_right ? job_reg.col_cur : job_reg.col_prev;
        tap.last   = (k == K_LOW_RIGHT);
    end

endmodule

### rtl/core/usm3_sharpen.sv
module usm3_sharpen (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  usm3_pkg::tap_t                in_tap,
    output logic                          in_ready,
    input  logic [usm3_pkg::GAIN_W-1:0]   direct_gain,
    input  logic [usm3_pkg::GAIN_W-1:0]   blur_gain,
    output logic                          out_valid,
    input  logic                          out_ready,
    output usm3_pkg::res_t                out_res
);
    import usm3_pkg::*;

    logic              v3_reg, v4_reg, vo_reg;
    logic              r3, r4, ro;
    tap_t              t3_reg;
    logic [PROD_W-1:0] pd_reg, pb_reg;
    tag_t              row4_reg, col4_reg;
    logic              last4_reg;
    logic [PROD_W-1:0] diff;
    logic [PROD_W-FRAC_W-1:0] whole;
    pix_t              pix_next;
    res_t              res_reg;

    // Stage ready chain, bubbles collapse
    assign ro       = !vo_reg || out_ready;
    assign r4       = !v4_reg || ro;
    assign r3       = !v3_reg || r4;
    assign in_ready = r3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (r3)
                v3_reg <= in_valid;
            if (r4)
                v4_reg <= v3_reg;
            if (ro)
                vo_reg <= v4_reg;
        end
    end

    // Clamp: negative to zero, drop fraction, saturate at full scale
    assign diff  = pd_reg - pb_reg;
    assign whole = diff[PROD_W-1:FRAC_W];

    always_comb
    begin
        if (pd_reg < pb_reg)
            pix_next = '0;
        else if (whole > (PROD_W-FRAC_W)'(PIX_MAX))
            pix_next = PIX_MAX;
        else
            pix_next = whole[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (r3)
            t3_reg <= in_tap;
        if (r4)
        begin
            pd_reg    <= PROD_W'(direct_gain) * PROD_W'(t3_reg.center);
            pb_reg    <= PROD_W'(blur_gain) * PROD_W'(t3_reg.blur);
            row4_reg  <= t3_reg.row;
            col4_reg  <= t3_reg.col;
            last4_reg <= t3_reg.last;
        end
        if (ro)
        begin
            res_reg.pixel <= pix_next;
            res_reg.row   <= row4_reg;
            res_reg.col   <= col4_reg;
            res_reg.last  <= last4_reg;
        end
    end

    assign out_valid = vo_reg;
    assign out_res   = res_reg;

endmodule

### rtl/core/unsharp_mask_3x3.sv
// A result appears on m_tvalid after the input item completing it passes the registered
// steps line-store read, window, blur, multiply, clamp. Throughput: one item per cycle
// unless stalled by a pending job or m_tready. Each last-row item gives 2 results (4 at
// the last column) through the single sharpen pipeline, so the next item of that row waits.
// Reset: counters, window, pipeline valids cleared, gains and sizes to defaults;
// line stores are not cleared and need no clearing pass.
module unsharp_mask_3x3 #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [usm3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [usm3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] pixel_in
    input  logic                               s_tuser,   // [0] frame_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] pixel_out, [16:8] out_row, [25:17] out_column, [31:26] zero
    output logic [usm3_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast    // frame_end
);
    import usm3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WZ = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int HZ = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

    logic [GAIN_W-1:0] direct_gain_reg, blur_gain_reg;
    logic [SIZE_W-1:0] frame_width_reg, frame_height_reg;
    logic [WZ-1:0]     fw_ext, w_use;
    logic [HZ-1:0]     fh_ext, h_use;
    logic [CW-1:0]     col_reg, cur_col;
    logic [RW-1:0]     row_reg, cur_row;
    logic              last_col, last_row, emit;
    logic              accept, commit;
    logic              s1_valid_reg;
    item_t             s1_item_reg, item_next;
    pix_t              cur_pix, above, above2;
    logic              job_free, job_busy, tap_valid, tap_ready;
    tap_t              tap;
    logic              res_valid;
    res_t              res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_gain_reg  <= DIRECT_GAIN_RESET;
            blur_gain_reg    <= BLUR_GAIN_RESET;
            frame_width_reg  <= FRAME_SIZE_RESET;
            frame_height_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIRECT_GAIN:  direct_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_BLUR_GAIN:    blur_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame size in use, clamped to 3..MAX
    assign fw_ext = WZ'(frame_width_reg);
    assign fh_ext = HZ'(frame_height_reg);

    always_comb
    begin
        if (fw_ext < WZ'(MIN_FRAME_SIZE))
            w_use = WZ'(MIN_FRAME_SIZE);
        else if (fw_ext > WZ'(MAX_WIDTH))
            w_use = WZ'(MAX_WIDTH);
        else
            w_use = fw_ext;

        if (fh_ext < HZ'(MIN_FRAME_SIZE))
            h_use = HZ'(MIN_FRAME_SIZE);
        else if (fh_ext > HZ'(MAX_HEIGHT))
            h_use = HZ'(MAX_HEIGHT);
        else
            h_use = fh_ext;
    end

    // Raster position of the incoming item
    assign accept   = s_tvalid && s_tready;
    assign cur_col  = s_tuser ? '0 : col_reg;
    assign cur_row  = s_tuser ? '0 : row_reg;
    assign last_col = (WZ'(cur_col) + WZ'(1)) >= w_use;
    assign last_row = (HZ'(cur_row) + HZ'(1)) >= h_use;
    assign emit     = (cur_row != '0) && (cur_col != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : cur_row + RW'(1);
            end
            else
            begin
                col_reg <= cur_col + CW'(1);
                row_reg <= cur_row;
            end
        end
    end

    // Results this item releases, with their row and column tags
    always_comb
    begin
        item_next.mask              = '0;
        item_next.mask[K_UP_LEFT]   = emit;
        item_next.mask[K_UP_RIGHT]  = emit && last_col;
        item_next.mask[K_LOW_LEFT]  = emit && last_row;
        item_next.mask[K_LOW_RIGHT] = emit && last_col && last_row;
        item_next.first_col         = (cur_col == CW'(1));
        item_next.first_row         = (cur_row == RW'(1));
        item_next.row_prev          = TAG_W'(cur_row - RW'(1));
        item_next.row_cur           = TAG_W'(cur_row);
        item_next.col_prev          = TAG_W'(cur_col - CW'(1));
        item_next.col_cur           = TAG_W'(cur_col);
    end

    // Line-store stage: waits here until the sequencer can take its job
    assign commit   = s1_valid_reg && ((s1_item_reg.mask == '0) || job_free);
    assign s_tready = !s1_valid_reg || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= item_next;
    end

    usm3_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .pix_in  (s_tdata),
        .wr_en   (commit),
        .cur_pix (cur_pix),
        .above   (above),
        .above2  (above2)
    );

    usm3_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .item      (s1_item_reg),
        .cur_pix   (cur_pix),
        .above     (above),
        .above2    (above2),
        .tap_ready (tap_ready),
        .job_free  (job_free),
        .job_busy  (job_busy),
        .tap_valid (tap_valid),
        .tap       (tap)
    );

    usm3_sharpen u_sharpen (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (tap_valid),
        .in_tap      (tap),
        .in_ready    (tap_ready),
        .direct_gain (direct_gain_reg),
        .blur_gain   (blur_gain_reg),
        .out_valid   (res_valid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    // Output packing
    assign m_tvalid = res_valid;
    assign m_tdata  = OUT_TDATA_W'({res.col, res.row, res.pixel});
    assign m_tlast  = res.last;

`ifndef SYNTHESIS
    // An item that releases results leaves a pending job behind
    a_job_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (s1_item_reg.mask != '0) |=> job_busy)
        else $error("job not loaded after commit");

    // Every accepted item lands in the line-store stage
    a_stage_filled: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted item lost");
`endif

endmodule
